### design/nbpc_pkg.sv
// Package for the nearest box point classifier.
// Holds command, status, register and state codes, the box entry, point, queue item and channel types.
`timescale 1ns / 1ps
`default_nettype none
package nbpc_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_LOAD     = 2'd1,
    CMD_CLASSIFY = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_STATIC  = 3'd0,
    ST_DYNAMIC = 3'd1,
    ST_STORED  = 3'd2,
    ST_DROPPED = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_GATE   = 2'd1,
    REG_MARGIN = 2'd2,
    REG_MASK   = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SCAN,
    BK_FETCH,
    BK_ROT,
    BK_TEST,
    BK_SEND
  } back_state_e;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic [11:0]        len;
    logic [11:0]        wid;
    logic [11:0]        hgt;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
    logic [3:0]         cls;
  } box_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
  } point_t;

  // Request handed from front to back: either a finished result or a point to scan.
  typedef struct packed {
    logic         scan;
    status_e      status;
    logic [5:0]   nearest;
    point_t       pt;
  } job_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  nearest_box;
  } result_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [11:0]        box_length;
    logic [11:0]        box_width;
    logic [11:0]        box_height;
    logic signed [15:0] yaw_cosine;
    logic signed [15:0] yaw_sine;
    logic [3:0]         box_class;
  } request_t;

endpackage
`default_nettype wire

### design/nbpc_if.sv
// Valid/ready channel interface for requests and results.
// Depends on nbpc_pkg for payload types.
`timescale 1ns / 1ps
`default_nettype none
interface nbpc_req_if;
  import nbpc_pkg::*;
  logic     valid;
  logic     ready;
  request_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nbpc_res_if;
  import nbpc_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/nbpc_front.sv
// Front part: accepts requests, owns the box table writes and count.
// Depends on nbpc_pkg; feeds jobs to the queue.
`timescale 1ns / 1ps
`default_nettype none
module nbpc_front #(
  parameter int MAX_BOXES = 64,
  parameter int CW = $clog2(MAX_BOXES + 1),
  parameter int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  nbpc_pkg::request_t   in_data_i,
  output logic                 job_valid_o,
  input  wire                  job_ready_i,
  output nbpc_pkg::job_t       job_o,
  input  wire                  back_busy_i,
  output logic                 wr_en_o,
  output logic [IW-1:0]        wr_addr_o,
  output nbpc_pkg::box_t       wr_data_o,
  output logic [CW-1:0]        count_o
);
  import nbpc_pkg::*;

  logic [CW-1:0] count_q, count_d;
  logic          take;

  // Hold table changes until any scan in flight has finished.
  assign in_ready_o  = job_ready_i && !back_busy_i;
  assign take        = in_valid_i && in_ready_o;
  assign job_valid_o = in_valid_i && !back_busy_i;
  assign count_o     = count_q;

  always_comb begin
    count_d        = count_q;
    wr_en_o        = 1'b0;
    wr_addr_o      = count_q[IW-1:0];
    wr_data_o      = '{cx: in_data_i.pos_x, cy: in_data_i.pos_y, cz: in_data_i.pos_z,
                       len: in_data_i.box_length, wid: in_data_i.box_width,
                       hgt: in_data_i.box_height, cs: in_data_i.yaw_cosine,
                       sn: in_data_i.yaw_sine, cls: in_data_i.box_class};
    job_o.scan     = 1'b0;
    job_o.status   = ST_STATIC;
    job_o.nearest  = '0;
    job_o.pt       = '{px: in_data_i.pos_x, py: in_data_i.pos_y, pz: in_data_i.pos_z};
    case (cmd_e'(in_data_i.command))
      CMD_CLEAR: begin
        job_o.status = ST_CLEARED;
        if (take) count_d = '0;
      end
      CMD_LOAD: begin
        if (count_q < CW'(MAX_BOXES)) begin
          job_o.status  = ST_STORED;
          job_o.nearest = 6'(count_q);
          if (take) begin
            wr_en_o = 1'b1;
            count_d = count_q + 1'b1;
          end
        end else begin
          job_o.status = ST_DROPPED;
        end
      end
      CMD_CLASSIFY: job_o.scan = (count_q != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end
endmodule
`default_nettype wire

### design/nbpc_queue.sv
// Two-entry queue that decouples the front from the back.
// Depends on nbpc_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none
module nbpc_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  nbpc_pkg::job_t  in_data_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output nbpc_pkg::job_t  out_data_o
);
  import nbpc_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### design/nbpc_back.sv
// Back part: box table memory, nearest centre scan and box test.
// Depends on nbpc_pkg; takes jobs from the queue and drives results.
`timescale 1ns / 1ps
`default_nettype none
module nbpc_back #(
  parameter int MAX_BOXES = 64,
  parameter int CW = $clog2(MAX_BOXES + 1),
  parameter int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  job_valid_i,
  output logic                 job_ready_o,
  input  nbpc_pkg::job_t       job_i,
  output logic                 busy_o,
  input  wire                  wr_en_i,
  input  wire [IW-1:0]         wr_addr_i,
  input  nbpc_pkg::box_t       wr_data_i,
  input  wire [CW-1:0]         count_i,
  input  wire                  box_mode_i,
  input  wire [31:0]           gate_i,
  input  wire [9:0]            margin_i,
  input  wire [15:0]           mask_i,
  output logic                 res_valid_o,
  input  wire                  res_ready_i,
  output nbpc_pkg::result_t    res_o
);
  import nbpc_pkg::*;

  box_t        mem_q [MAX_BOXES];
  box_t        rd_q;
  logic [IW-1:0] rd_addr;

  back_state_e state_q, state_d;
  point_t      pt_q;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] best_q, best_d;
  logic [34:0] best_dist_q, best_dist_d;
  logic        res_valid_q, res_valid_d;
  result_t     res_q, res_d;
  logic signed [33:0] lx_q, ly_q, lx_d, ly_d;
  logic signed [16:0] dz_q, dz_d;

  logic signed [16:0] ex, ey, ez;
  logic [34:0] dist_sq;
  logic signed [33:0] cdx, sdy, sdx, cdy;
  logic [33:0] ax, ay;
  logic [16:0] az;
  logic [12:0] m2;
  logic        in_box;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    rd_q <= mem_q[rd_addr];
  end

  assign ex   = 17'(pt_q.px) - 17'(rd_q.cx);
  assign ey   = 17'(pt_q.py) - 17'(rd_q.cy);
  assign ez   = 17'(pt_q.pz) - 17'(rd_q.cz);
  assign dist_sq = 35'(unsigned'(34'(ex * ex))) + 35'(unsigned'(34'(ey * ey)))
                 + 35'(unsigned'(34'(ez * ez)));

  assign cdx = 34'(rd_q.cs * ex);
  assign sdy = 34'(rd_q.sn * ey);
  assign sdx = 34'(rd_q.sn * ex);
  assign cdy = 34'(rd_q.cs * ey);

  assign m2 = {margin_i, 1'b0} + 13'd0;
  assign ax = lx_q[33] ? 34'(-lx_q) : 34'(lx_q);
  assign ay = ly_q[33] ? 34'(-ly_q) : 34'(ly_q);
  assign az = dz_q[16] ? 17'(-dz_q) : 17'(dz_q);
  assign in_box = ({ax, 1'b0} <= 35'(rd_q.len) + 35'(m2))
               && ({ay, 1'b0} <= 35'(rd_q.wid) + 35'(m2))
               && ({az, 1'b0} <= 18'(rd_q.hgt) + 18'(m2));

  assign job_ready_o = (state_q == BK_IDLE) && !res_valid_q;
  assign busy_o      = (state_q != BK_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    best_d      = best_q;
    best_dist_d = best_dist_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    lx_d        = lx_q;
    ly_d        = ly_q;
    dz_d        = dz_q;
    rd_addr     = idx_q[IW-1:0];
    case (state_q)
      BK_IDLE: begin
        rd_addr = '0;
        if (job_valid_i && job_ready_o) begin
          if (job_i.scan) begin
            idx_d   = CW'(1);
            state_d = BK_SCAN;
          end else begin
            res_valid_d = 1'b1;
            res_d       = '{status: job_i.status, nearest_box: job_i.nearest};
          end
        end
      end
      BK_SCAN: begin
        // rd_q holds entry idx_q-1; compare and fetch the next.
        if (idx_q == CW'(1) || dist_sq < best_dist_q) begin
          best_dist_d = dist_sq;
          best_d      = IW'(idx_q - 1'b1);
        end
        if (idx_q == count_i) begin
          state_d = BK_FETCH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      BK_FETCH: begin
        rd_addr = best_q;
        state_d = BK_READ;
      end
      BK_READ: begin
        rd_addr = best_q;
        state_d = BK_ROT;
        if (best_dist_q > 35'(gate_i) ||
            (!box_mode_i && !mask_i[rd_q.cls])) begin
          res_d   = '{status: ST_STATIC, nearest_box: 6'(best_q)};
          state_d = BK_SEND;
        end
      end
      BK_ROT: begin
        rd_addr = best_q;
        dz_d    = ez;
        if (!box_mode_i) begin
          lx_d = (cdx - sdy) >>> 14;
          ly_d = (sdx + cdy) >>> 14;
        end else begin
          lx_d = 34'(ex);
          ly_d = 34'(ey);
        end
        state_d = BK_TEST;
      end
      BK_TEST: begin
        rd_addr = best_q;
        res_d   = '{status: in_box ? ST_DYNAMIC : ST_STATIC, nearest_box: 6'(best_q)};
        state_d = BK_SEND;
      end
      BK_SEND: begin
        if (!res_valid_q) begin
          res_valid_d = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q        <= (state_q == BK_IDLE) ? job_i.pt : pt_q;
    best_q      <= best_d;
    best_dist_q <= best_dist_d;
    res_q       <= res_d;
    lx_q        <= lx_d;
    ly_q        <= ly_d;
    dz_q        <= dz_d;
  end
endmodule
`default_nettype wire

### design/nearest_box_point_classifier_core.sv
// Nearest box point classifier, top level.
// Request channel in, result channel out, one result per request. Commands:
// clear the box table, load one box, classify one point. Front part handles
// requests and table writes, a two-entry queue decouples it from the back
// part, which scans the table for the nearest centre and tests the box.
// Clear, load, unused commands and points on an empty table: the request goes
// through the queue and its result is registered in the output register; the
// next request is taken once the previous one has left the queue.
// Classify: one box centre per cycle through the table read port, then the
// states fetch, read, rotate, test and send lead to the result; the read state
// goes to send when the gate or the class filter makes the point static.
// A new request waits while a request sits in the queue or a scan runs, so
// the table never changes under a scan.
// Reset clears the box count and the configuration registers to defaults;
// the table needs no clearing. When the receiver stalls, the result is held
// in the output register, the next request waits in the queue, then the
// request side stalls.
// Configuration is written through cfg_we_i, cfg_index_i, cfg_data_i.
// Depends on nbpc_pkg, the channel interfaces and the front, queue and back parts.
`timescale 1ns / 1ps
`default_nettype none
module nearest_box_point_classifier_core #(
  parameter int MAX_BOXES = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  nbpc_req_if.sink   req,
  nbpc_res_if.source res,
  input  wire        cfg_we_i,
  input  wire [1:0]  cfg_index_i,
  input  wire [31:0] cfg_data_i
);
  import nbpc_pkg::*;

  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  logic        mode_q;
  logic [31:0] gate_q;
  logic [9:0]  margin_q;
  logic [15:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      gate_q   <= 32'd262144;
      margin_q <= 10'd51;
      mask_q   <= 16'd321;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_MODE:   mode_q   <= cfg_data_i[0];
        REG_GATE:   gate_q   <= cfg_data_i;
        REG_MARGIN: margin_q <= cfg_data_i[9:0];
        REG_MASK:   mask_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic          fj_valid, fj_ready, bj_valid, bj_ready, back_busy, wr_en;
  logic          hold_front;
  job_t          fj, bj;
  logic [IW-1:0] wr_addr;
  box_t          wr_data;
  logic [CW-1:0] count;

  // Hold new requests while one is queued or the back part is working.
  assign hold_front = back_busy || bj_valid;

  nbpc_front #(.MAX_BOXES(MAX_BOXES)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready), .in_data_i(req.data),
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj),
    .back_busy_i(hold_front),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data), .count_o(count)
  );

  nbpc_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(fj_valid), .in_ready_o(fj_ready), .in_data_i(fj),
    .out_valid_o(bj_valid), .out_ready_i(bj_ready), .out_data_o(bj)
  );

  nbpc_back #(.MAX_BOXES(MAX_BOXES)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .busy_o(back_busy),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data), .count_i(count),
    .box_mode_i(mode_q), .gate_i(gate_q), .margin_i(margin_q), .mask_i(mask_q),
    .res_valid_o(res.valid), .res_ready_i(res.ready), .res_o(res.data)
  );
endmodule
`default_nettype wire

### design/nbpc_checker.sv
// Port-level checker for the classifier, bound to the top level.
// Depends on nbpc_pkg for status codes.
`timescale 1ns / 1ps
`default_nettype none
module nbpc_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        res_valid,
  input wire        res_ready,
  input wire [2:0]  res_status,
  input wire [5:0]  res_near
);
  import nbpc_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_status))
    else $error("result dropped while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_status <= 3'(ST_CLEARED))
    else $error("bad status code");

  a_clear_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_status == 3'(ST_CLEARED) || res_status == 3'(ST_DROPPED))
      |-> res_near == 6'd0)
    else $error("nonzero index on clear or drop");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !res_valid)
    else $error("result right after reset");
endmodule

bind nearest_box_point_classifier_core nbpc_checker u_nbpc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .res_valid(res.valid), .res_ready(res.ready), .res_status(res.data.status),
  .res_near(res.data.nearest_box)
);
`default_nettype wire
